// File: src/gnss_ps_pkg.sv
// Shared widths, constants and sequencer state codes for the GNSS position smoother.
// Used by gnss_position_smoother_top; depends on nothing else.
`default_nettype none

package gnss_ps_pkg;

  localparam int TIME_W   = 30;
  localparam int POS_W    = 36;
  localparam int VEL_W    = 24;
  localparam int DT_W     = 32;
  localparam int PROD_W   = VEL_W + DT_W;          // velocity times dt
  localparam int PRED_W   = 48;                    // predicted position, full width
  localparam int ACC_W    = 66;                    // blend accumulator
  localparam int MOVE_SH  = 10;                    // 1/1024 s time unit
  localparam int BLEND_SH = 16;                    // Q16 weights
  localparam int NP_W     = ACC_W - BLEND_SH;      // blended position before saturation

  localparam int DEFAULT_AXIS_COUNT = 3;
  localparam int MAX_AXES           = 3;

  // stream payload layout, lowest bit first
  localparam int TDATA_W   = 216;
  localparam int TUSER_W   = 1;
  localparam int TIME_LSB  = 0;
  localparam int POS_LSB   = TIME_LSB + TIME_W;
  localparam int VEL_LSB   = POS_LSB + MAX_AXES * POS_W;
  localparam int DATA_BITS = VEL_LSB + MAX_AXES * VEL_W;

  localparam logic signed [DT_W-1:0] WEEK_TICKS      = 32'sd619315200;
  localparam logic signed [DT_W-1:0] HALF_WEEK_TICKS = 32'sd309657600;

  // 0.8 = 4 * 0.2 + 1 LSB in Q16, so the blend is W_MEAS * (4 * pred + meas) + pred
  localparam logic signed [ACC_W-1:0] W_MEAS     = 66'sd13107;
  localparam logic signed [ACC_W-1:0] BLEND_HALF = 66'sd32768;
  localparam logic signed [PROD_W:0]  MOVE_HALF  = 57'sd512;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DT    = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_PRED  = 7'b0001000,
    ST_BLEND = 7'b0010000,
    ST_SAT   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } seq_state_t;

endpackage

`default_nettype wire

// File: src/gnss_position_smoother_top.sv
// GNSS position smoother: velocity-aided alpha filter over ECEF position fixes.
// Depends on gnss_ps_pkg for widths, constants and sequencer codes.
//
// One fix in, one result out. Before the filter holds an estimate, a fix flagged
// new loads it; every later fix is smoothed: dt is taken from the stored time and
// wrapped once across the week boundary, each axis is predicted as position plus
// velocity times dt (rounded from 1/1024 s), blended 0.8 prediction / 0.2
// measurement, and saturated to 36 bits; velocity and time are replaced.
// The datapath is one shared signed multiplier (velocity x dt) and one blend
// multiply-add, run per axis under a sequencer: DT, then MUL, PRED, BLEND and
// SAT for each axis, then DONE; a loading or ignored fix goes straight to DONE.
// The input is not ready while a fix is in work; the result sits in an output
// register, so the next fix is taken while the result waits downstream.
`default_nettype none

module gnss_position_smoother_top #(
  parameter int AXIS_COUNT = gnss_ps_pkg::DEFAULT_AXIS_COUNT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // time_of_week[29:0], meas_pos_x/y/z[36 each], meas_vel_x/y/z[24 each], zero pad
  input  wire logic [gnss_ps_pkg::TDATA_W-1:0]  s_axis_tdata,
  // fix_is_new
  input  wire logic [gnss_ps_pkg::TUSER_W-1:0]  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_time[29:0], smooth_pos_x/y/z[36 each], held_vel_x/y/z[24 each], zero pad
  output logic [gnss_ps_pkg::TDATA_W-1:0]       m_axis_tdata,
  // is_initialized
  output logic [gnss_ps_pkg::TUSER_W-1:0]       m_axis_tuser
);

  localparam int TIME_W  = gnss_ps_pkg::TIME_W;
  localparam int POS_W   = gnss_ps_pkg::POS_W;
  localparam int VEL_W   = gnss_ps_pkg::VEL_W;
  localparam int DT_W    = gnss_ps_pkg::DT_W;
  localparam int PROD_W  = gnss_ps_pkg::PROD_W;
  localparam int PRED_W  = gnss_ps_pkg::PRED_W;
  localparam int ACC_W   = gnss_ps_pkg::ACC_W;
  localparam int NP_W    = gnss_ps_pkg::NP_W;
  localparam int MOVE_W  = PROD_W + 1 - gnss_ps_pkg::MOVE_SH;
  localparam int NAXES   = gnss_ps_pkg::MAX_AXES;
  localparam int AX_W    = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXIS_COUNT - 1);

  // estimate state
  gnss_ps_pkg::seq_state_t state;
  logic                           init_flag;
  logic        [TIME_W-1:0]       est_time;
  logic signed [POS_W-1:0]        est_pos [AXIS_COUNT];
  logic signed [VEL_W-1:0]        est_vel [AXIS_COUNT];

  // captured fix
  logic        [TIME_W-1:0]       fix_time;
  logic signed [POS_W-1:0]        fix_pos [AXIS_COUNT];
  logic signed [VEL_W-1:0]        fix_vel [AXIS_COUNT];

  // shared datapath registers
  logic        [AX_W-1:0]         ax;
  logic signed [DT_W-1:0]         dt;
  logic signed [PROD_W-1:0]       prod;
  logic signed [PRED_W-1:0]       pred;
  logic signed [ACC_W-1:0]        acc;

  // output register
  logic                           out_init;
  logic        [TIME_W-1:0]       out_time;
  logic signed [POS_W-1:0]        out_pos [NAXES];
  logic signed [VEL_W-1:0]        out_vel [NAXES];

  logic                           in_xfer;
  logic                           out_free;
  logic signed [POS_W-1:0]        in_pos [NAXES];
  logic signed [VEL_W-1:0]        in_vel [NAXES];
  logic signed [POS_W-1:0]        view_pos [NAXES];
  logic signed [VEL_W-1:0]        view_vel [NAXES];

  logic signed [DT_W-1:0]         dt_raw;
  logic signed [DT_W-1:0]         dt_wrap;
  logic signed [PROD_W:0]         move_sum;
  logic signed [MOVE_W-1:0]       move;
  logic signed [ACC_W-1:0]        blend_in;
  logic signed [NP_W-1:0]         np;
  logic                           np_ovf;
  logic signed [POS_W-1:0]        np_sat;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == gnss_ps_pkg::ST_IDLE);

  for (genvar a = 0; a < NAXES; a++) begin : g_axis
    assign in_pos[a] = s_axis_tdata[gnss_ps_pkg::POS_LSB + a*POS_W +: POS_W];
    assign in_vel[a] = s_axis_tdata[gnss_ps_pkg::VEL_LSB + a*VEL_W +: VEL_W];
    if (a < AXIS_COUNT) begin : g_live
      assign view_pos[a] = est_pos[a];
      assign view_vel[a] = est_vel[a];
    end else begin : g_off
      assign view_pos[a] = '0;
      assign view_vel[a] = '0;
    end
    assign m_axis_tdata[gnss_ps_pkg::POS_LSB + a*POS_W +: POS_W] = out_pos[a];
    assign m_axis_tdata[gnss_ps_pkg::VEL_LSB + a*VEL_W +: VEL_W] = out_vel[a];
  end

  assign m_axis_tdata[gnss_ps_pkg::TIME_LSB +: TIME_W] = out_time;
  assign m_axis_tdata[gnss_ps_pkg::TDATA_W-1:gnss_ps_pkg::DATA_BITS] = '0;
  assign m_axis_tuser = gnss_ps_pkg::TUSER_W'(out_init);

  // elapsed time, wrapped once across the week boundary
  always_comb begin
    dt_raw = DT_W'($signed({2'b00, fix_time})) - DT_W'($signed({2'b00, est_time}));
    if (dt_raw < -gnss_ps_pkg::HALF_WEEK_TICKS) begin
      dt_wrap = dt_raw + gnss_ps_pkg::WEEK_TICKS;
    end else if (dt_raw > gnss_ps_pkg::HALF_WEEK_TICKS) begin
      dt_wrap = dt_raw - gnss_ps_pkg::WEEK_TICKS;
    end else begin
      dt_wrap = dt_raw;
    end
  end

  // round half up from 1/1024 s, then the blend operand 4 * pred + meas
  always_comb begin
    move_sum = (PROD_W+1)'(prod) + gnss_ps_pkg::MOVE_HALF;
    move     = move_sum[PROD_W:gnss_ps_pkg::MOVE_SH];
    blend_in = (ACC_W'(pred) <<< 2) + ACC_W'(fix_pos[ax]);
  end

  // floor by 2^16 and clamp to the 36-bit range
  always_comb begin
    np     = acc[ACC_W-1:gnss_ps_pkg::BLEND_SH];
    np_ovf = !((&np[NP_W-1:POS_W-1]) || !(|np[NP_W-1:POS_W-1]));
    if (np_ovf) begin
      np_sat = np[NP_W-1] ? gnss_ps_pkg::POS_MIN : gnss_ps_pkg::POS_MAX;
    end else begin
      np_sat = np[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gnss_ps_pkg::ST_IDLE;
      init_flag     <= 1'b0;
      est_time      <= '0;
      ax            <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        est_pos[i] <= '0;
        est_vel[i] <= '0;
      end
    end else begin
      // offer a finished fix, else drop valid once the transfer completes
      if (state == gnss_ps_pkg::ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        gnss_ps_pkg::ST_IDLE: begin
          if (in_xfer) begin
            fix_time <= s_axis_tdata[gnss_ps_pkg::TIME_LSB +: TIME_W];
            for (int i = 0; i < AXIS_COUNT; i++) begin
              fix_pos[i] <= in_pos[i];
              fix_vel[i] <= in_vel[i];
            end
            ax <= '0;
            if (init_flag) begin
              state <= gnss_ps_pkg::ST_DT;
            end else begin
              // load the estimate straight from a new fix, else hold
              if (s_axis_tuser[0]) begin
                for (int i = 0; i < AXIS_COUNT; i++) begin
                  est_pos[i] <= in_pos[i];
                  est_vel[i] <= in_vel[i];
                end
                est_time  <= s_axis_tdata[gnss_ps_pkg::TIME_LSB +: TIME_W];
                init_flag <= 1'b1;
              end
              state <= gnss_ps_pkg::ST_DONE;
            end
          end
        end
        gnss_ps_pkg::ST_DT: begin
          dt    <= dt_wrap;
          state <= gnss_ps_pkg::ST_MUL;
        end
        gnss_ps_pkg::ST_MUL: begin
          prod  <= PROD_W'(est_vel[ax]) * PROD_W'(dt);
          state <= gnss_ps_pkg::ST_PRED;
        end
        gnss_ps_pkg::ST_PRED: begin
          pred  <= PRED_W'(est_pos[ax]) + PRED_W'(move);
          state <= gnss_ps_pkg::ST_BLEND;
        end
        gnss_ps_pkg::ST_BLEND: begin
          acc   <= blend_in * gnss_ps_pkg::W_MEAS + ACC_W'(pred) + gnss_ps_pkg::BLEND_HALF;
          state <= gnss_ps_pkg::ST_SAT;
        end
        gnss_ps_pkg::ST_SAT: begin
          est_pos[ax] <= np_sat;
          est_vel[ax] <= fix_vel[ax];
          if (ax == AX_LAST) begin
            est_time <= fix_time;
            state    <= gnss_ps_pkg::ST_DONE;
          end else begin
            ax    <= ax + 1'b1;
            state <= gnss_ps_pkg::ST_MUL;
          end
        end
        gnss_ps_pkg::ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            state <= gnss_ps_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= gnss_ps_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded as the transfer is offered
  always_ff @(posedge clk) begin
    if (state == gnss_ps_pkg::ST_DONE && out_free) begin
      out_init <= init_flag;
      out_time <= est_time;
      for (int i = 0; i < NAXES; i++) begin
        out_pos[i] <= view_pos[i];
        out_vel[i] <= view_vel[i];
      end
    end
  end

  a_init_sticky: assert property (@(posedge clk) disable iff (rst)
    init_flag |=> init_flag)
    else $error("initialized flag fell without reset");

  a_result_offered: assert property (@(posedge clk) disable iff (rst)
    (state == gnss_ps_pkg::ST_DONE && out_free) |=> m_axis_tvalid)
    else $error("finished fix not offered on the output");

  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == gnss_ps_pkg::ST_DT || state == gnss_ps_pkg::ST_DONE))
    else $error("accepted fix did not start the sequencer");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    (state == gnss_ps_pkg::ST_MUL || state == gnss_ps_pkg::ST_SAT) |-> (ax <= AX_LAST))
    else $error("axis counter past the last axis");

  a_result_init: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> init_flag)
    else $error("result claims an estimate the filter does not hold");

endmodule

`default_nettype wire
